FILE: rtl/core/rwf_pkg.sv
`default_nettype none
package rwf_pkg;

  // Address width of the register memory, sized for the largest ring (32 windows + globals)
  localparam int ADDR_W = 10;

  localparam logic [2:0] FN_READ       = 3'd0;
  localparam logic [2:0] FN_WRITE      = 3'd1;
  localparam logic [2:0] FN_SAVE       = 3'd2;
  localparam logic [2:0] FN_RESTORE    = 3'd3;
  localparam logic [2:0] FN_SET_WINDOW = 3'd4;

  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_SPILL     = 3'd1;
  localparam logic [2:0] ST_CLEAN     = 3'd2;
  localparam logic [2:0] ST_FILL      = 3'd3;
  localparam logic [2:0] ST_INVARIANT = 3'd4;
  localparam logic [2:0] ST_BADWIN    = 3'd5;

  localparam logic [1:0] CFG_ALT_GLOBALS   = 2'd0;
  localparam logic [1:0] CFG_OTHER_WINDOWS = 2'd1;
  localparam logic [1:0] CFG_CLEAN_WINDOWS = 2'd2;

  localparam logic [1:0] GRP_GLOBAL = 2'd0;
  localparam logic [1:0] GRP_OUT    = 2'd1;
  localparam logic [1:0] GRP_LOCAL  = 2'd2;

  typedef struct packed {
    logic [2:0]         func;
    logic [4:0]         reg_index;
    logic [63:0]        write_value;
    logic signed [63:0] operand_a;
    logic signed [63:0] operand_b;
    logic [4:0]         window_select;
  } in_item_t;

  typedef struct packed {
    logic [63:0]        read_value;
    logic signed [63:0] sum_value;
    logic [2:0]         status;
  } out_item_t;

  typedef struct packed {
    logic              we;
    logic              re;
    logic [ADDR_W-1:0] addr;
    logic [63:0]       wdata;
  } mem_req_t;

  typedef struct packed {
    logic               is_read;
    logic signed [63:0] sum_value;
    logic [2:0]         status;
  } res_info_t;

  typedef enum logic {
    MS_CLEAR,
    MS_RUN
  } mem_state_t;

endpackage
`default_nettype wire

FILE: rtl/core/rwf_regmem.sv
`default_nettype none
module rwf_regmem
  import rwf_pkg::*;
#(
  parameter int AW    = 8,
  parameter int DEPTH = 144
) (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire mem_req_t req,
  output logic [63:0]   rdata,
  output logic          busy
);

  logic [63:0]   mem [DEPTH];
  logic [63:0]   rdata_r;
  mem_state_t    state_r, state_nxt;
  logic [AW-1:0] clr_addr_r, clr_addr_nxt;
  logic          wr_en;
  logic [AW-1:0] wr_addr;
  logic [63:0]   wr_data;

  localparam logic [AW-1:0] LAST_ADDR = AW'(DEPTH - 1);

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      MS_CLEAR: if (clr_addr_r == LAST_ADDR) state_nxt = MS_RUN;
      MS_RUN:   state_nxt = MS_RUN;
      default:  state_nxt = MS_CLEAR;
    endcase
  end

  always_comb begin
    busy         = 1'b0;
    clr_addr_nxt = clr_addr_r;
    wr_en        = req.we;
    wr_addr      = req.addr[AW-1:0];
    wr_data      = req.wdata;
    unique case (state_r)
      MS_CLEAR: begin
        // zero one entry a cycle until the sweep reaches the top
        busy         = 1'b1;
        clr_addr_nxt = clr_addr_r + 1'b1;
        wr_en        = 1'b1;
        wr_addr      = clr_addr_r;
        wr_data      = '0;
      end
      MS_RUN: begin
        busy = 1'b0;
      end
      default: begin
        busy = 1'b1;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= MS_CLEAR;
      clr_addr_r <= '0;
    end else begin
      state_r    <= state_nxt;
      clr_addr_r <= clr_addr_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
  end

  always_ff @(posedge clk) begin
    if (req.re) rdata_r <= mem[req.addr[AW-1:0]];
  end

  assign rdata = rdata_r;

endmodule
`default_nettype wire

FILE: rtl/core/rwf_window_ctrl.sv
`default_nettype none
module rwf_window_ctrl
  import rwf_pkg::*;
#(
  parameter int NUM_WINDOWS = 8
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       cfg_we,
  input  wire logic [1:0] cfg_index,
  input  wire logic [2:0] cfg_wdata,
  input  wire logic       accept,
  input  wire in_item_t   item,
  output mem_req_t        mem_req,
  output res_info_t       res
);

  localparam int CW = $clog2(NUM_WINDOWS);
  localparam int RW = $clog2(NUM_WINDOWS + 1);
  localparam int EW = ((CW > 3) ? CW : 3) + 2;
  localparam logic [CW-1:0] LAST = CW'(NUM_WINDOWS - 1);

  logic          alt_globals_r;
  logic [2:0]    other_windows_r;
  logic [2:0]    clean_windows_r;
  logic [CW-1:0] current_window_r, current_window_nxt;
  logic [CW-1:0] can_save_r, can_save_nxt;
  logic [CW-1:0] can_restore_r, can_restore_nxt;

  logic [CW-1:0] cw_up, cw_dn, cs_up, cs_dn, cr_up, cr_dn;
  logic [1:0]    grp;
  logic [2:0]    k;
  logic [RW-1:0] row;
  logic [3:0]    low;
  logic [EW-1:0] win_total;
  logic [2:0]    status;
  logic          moved;

  assign cw_up = (current_window_r == LAST) ? '0 : current_window_r + 1'b1;
  assign cw_dn = (current_window_r == '0) ? LAST : current_window_r - 1'b1;
  assign cs_up = (can_save_r == LAST) ? '0 : can_save_r + 1'b1;
  assign cs_dn = (can_save_r == '0) ? LAST : can_save_r - 1'b1;
  assign cr_up = (can_restore_r == LAST) ? '0 : can_restore_r + 1'b1;
  assign cr_dn = (can_restore_r == '0) ? LAST : can_restore_r - 1'b1;

  assign win_total = EW'(can_save_r) + EW'(can_restore_r) + EW'(other_windows_r);

  // globals sit in the row just above the ring
  assign grp = item.reg_index[4:3];
  assign k   = item.reg_index[2:0];

  always_comb begin
    case (grp)
      GRP_GLOBAL: begin
        row = RW'(NUM_WINDOWS);
        low = {alt_globals_r, k};
      end
      GRP_OUT: begin
        row = RW'(cw_up);
        low = {1'b0, k};
      end
      GRP_LOCAL: begin
        row = RW'(current_window_r);
        low = {1'b1, k};
      end
      default: begin
        row = RW'(current_window_r);
        low = {1'b0, k};
      end
    endcase
  end

  always_comb begin
    status             = ST_OK;
    moved              = 1'b0;
    current_window_nxt = current_window_r;
    can_save_nxt       = can_save_r;
    can_restore_nxt    = can_restore_r;
    unique case (item.func)
      FN_SAVE: begin
        if (can_save_r == '0) begin
          status = ST_SPILL;
        end else if (EW'(clean_windows_r) == EW'(can_restore_r)) begin
          status = ST_CLEAN;
        end else if (win_total != EW'(NUM_WINDOWS - 2)) begin
          status = ST_INVARIANT;
        end else begin
          moved              = 1'b1;
          current_window_nxt = cw_up;
          can_save_nxt       = cs_dn;
          can_restore_nxt    = cr_up;
        end
      end
      FN_RESTORE: begin
        if (can_restore_r == '0) begin
          status = ST_FILL;
        end else begin
          moved              = 1'b1;
          current_window_nxt = cw_dn;
          can_save_nxt       = cs_up;
          can_restore_nxt    = cr_dn;
        end
      end
      FN_SET_WINDOW: begin
        if ({1'b0, item.window_select} >= 6'(NUM_WINDOWS)) begin
          status = ST_BADWIN;
        end else begin
          current_window_nxt = item.window_select[CW-1:0];
        end
      end
      default: begin
        status = ST_OK;
      end
    endcase
  end

  always_comb begin
    mem_req.re    = accept && (item.func == FN_READ);
    // drop writes to global zero
    mem_req.we    = accept && (item.func == FN_WRITE) && !((grp == GRP_GLOBAL) && (k == 3'd0));
    mem_req.addr  = ADDR_W'({row, low});
    mem_req.wdata = item.write_value;
    res.is_read   = (item.func == FN_READ);
    res.sum_value = moved ? item.operand_a + item.operand_b : '0;
    res.status    = status;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      alt_globals_r    <= 1'b0;
      other_windows_r  <= 3'd0;
      clean_windows_r  <= 3'd6;
      current_window_r <= '0;
      can_save_r       <= CW'(NUM_WINDOWS - 2);
      can_restore_r    <= '0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_ALT_GLOBALS:   alt_globals_r   <= cfg_wdata[0];
          CFG_OTHER_WINDOWS: other_windows_r <= cfg_wdata;
          CFG_CLEAN_WINDOWS: clean_windows_r <= cfg_wdata;
          default: ;
        endcase
      end
      if (accept) begin
        current_window_r <= current_window_nxt;
        can_save_r       <= can_save_nxt;
        can_restore_r    <= can_restore_nxt;
      end
    end
  end

  a_window_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    current_window_r <= LAST && can_save_r <= LAST && can_restore_r <= LAST)
    else $error("window counter out of range");

  a_save_steps_restore: assert property (@(posedge clk) disable iff (!rst_n)
    accept && item.func == FN_SAVE && status == ST_OK |=>
    can_restore_r == (($past(can_restore_r) == LAST) ? '0 : $past(can_restore_r) + 1'b1))
    else $error("save did not advance can_restore");

  a_trap_holds_window: assert property (@(posedge clk) disable iff (!rst_n)
    accept && (item.func == FN_SAVE || item.func == FN_RESTORE) && status != ST_OK |=>
    $stable(current_window_r))
    else $error("trapped window move changed the current window");

endmodule
`default_nettype wire

FILE: rtl/core/register_window_file.sv
`default_nettype none
// Channel  Direction  Handshake              Payload
// in       input      in_valid / in_ready    in_data (in_item_t)
// out      output     out_valid / out_ready  out_data (out_item_t)
// cfg      input      cfg_we                 cfg_index, cfg_wdata
//
// One item a cycle unless the output stalls or the clearing pass runs: an accepted
// beat reads or writes the register memory at its accept edge, and its result
// passes through the stage-one register into the output register, as the single
// read port of the register memory is registered. After reset a clearing pass zeroes
// the memory, during which in_ready stays low; configuration writes are taken throughout.
// A stalled output holds one result plus one more in flight, then drops in_ready.
module register_window_file
  import rwf_pkg::*;
#(
  parameter int NUM_WINDOWS = 8
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire in_item_t   in_data,
  output logic            out_valid,
  input  wire logic       out_ready,
  output out_item_t       out_data,
  input  wire logic       cfg_we,
  input  wire logic [1:0] cfg_index,
  input  wire logic [2:0] cfg_wdata
);

  localparam int DEPTH = NUM_WINDOWS * 16 + 16;
  localparam int AW    = $clog2(DEPTH);

  mem_req_t    mem_req;
  res_info_t   res;
  logic [63:0] rdata;
  logic        mem_busy;
  logic        accept;
  logic        s1_move;

  logic        s1_valid_r, s1_valid_nxt;
  res_info_t   s1_res_r;
  logic        out_valid_r, out_valid_nxt;
  out_item_t   out_data_r;

  rwf_window_ctrl #(
    .NUM_WINDOWS(NUM_WINDOWS)
  ) u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata),
    .accept   (accept),
    .item     (in_data),
    .mem_req  (mem_req),
    .res      (res)
  );

  rwf_regmem #(
    .AW   (AW),
    .DEPTH(DEPTH)
  ) u_mem (
    .clk  (clk),
    .rst_n(rst_n),
    .req  (mem_req),
    .rdata(rdata),
    .busy (mem_busy)
  );

  // read data stays put while the stage stalls: reads issue only on accept
  assign s1_move  = s1_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !mem_busy && (!s1_valid_r || s1_move);
  assign accept   = in_valid && in_ready;

  always_comb begin
    s1_valid_nxt  = accept ? 1'b1 : (s1_move ? 1'b0 : s1_valid_r);
    out_valid_nxt = s1_move ? 1'b1 : (out_ready ? 1'b0 : out_valid_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) s1_res_r <= res;
    if (s1_move) begin
      out_data_r.read_value <= s1_res_r.is_read ? rdata : 64'd0;
      out_data_r.sum_value  <= s1_res_r.sum_value;
      out_data_r.status     <= s1_res_r.status;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  a_no_accept_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
    mem_busy |-> !in_ready)
    else $error("beat accepted during clearing pass");

  a_stage_holds: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r && !s1_move |=> s1_valid_r && $stable(s1_res_r))
    else $error("stalled stage lost its beat");

  a_trap_no_sum: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_data_r.status != ST_OK |-> out_data_r.sum_value == 64'sd0)
    else $error("trapped result carries a sum");

endmodule
`default_nettype wire
